>>> rtl/bthd_pkg.sv
// shared types for the tag header decoder
// parser state, result record and field kind codes; no dependencies
package bthd_pkg;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'b0001,
        PH_EXT_TAG   = 4'b0010,
        PH_LEN_FIRST = 4'b0100,
        PH_LEN_MORE  = 4'b1000
    } phase_t;

    localparam logic [1:0] KIND_LENGTH  = 2'd0;
    localparam logic [1:0] KIND_BOOLEAN = 2'd1;
    localparam logic [1:0] KIND_OPENING = 2'd2;
    localparam logic [1:0] KIND_CLOSING = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_RSV_TAG  = 2'd1;
    localparam logic [1:0] STAT_BAD_BOOL = 2'd2;

    localparam logic [2:0] LVT_EXT_LEN = 3'd5;
    localparam logic [2:0] LVT_OPENING = 3'd6;
    localparam logic [2:0] LVT_CLOSING = 3'd7;
    localparam logic [3:0] TAG_EXTENDED = 4'hF;
    localparam logic [7:0] TAG_RESERVED = 8'hFF;
    localparam logic [7:0] TAG_APP_BOOL = 8'd1;
    localparam logic [7:0] LEN_MARK_16 = 8'd254;
    localparam logic [7:0] LEN_MARK_32 = 8'd255;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  tag_number;
        logic        context_class;
        logic [2:0]  lvt;
        logic [31:0] length_acc;
        logic [2:0]  bytes_remaining;
        logic [2:0]  bytes_seen;
    } parse_state_t;

    typedef struct packed {
        logic [7:0]  tag_number;
        logic        is_context;
        logic [1:0]  field_kind;
        logic [31:0] length_value;
        logic        bool_value;
        logic [2:0]  header_bytes;
        logic [1:0]  status;
    } result_t;

endpackage

>>> rtl/bthd_stream_if.sv
// valid/ready channel interfaces for the tag header decoder
// byte input channel and decoded header output channel; no dependencies
interface bthd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       header_start;

    modport source (output valid, output byte_in, output header_start, input ready);
    modport sink (input valid, input byte_in, input header_start, output ready);
endinterface

interface bthd_hdr_if;
    logic        valid;
    logic        ready;
    logic [7:0]  tag_number;
    logic        is_context;
    logic [1:0]  field_kind;
    logic [31:0] length_value;
    logic        bool_value;
    logic [2:0]  header_bytes;
    logic [1:0]  status;

    modport source (output valid, output tag_number, output is_context, output field_kind,
                    output length_value, output bool_value, output header_bytes,
                    output status, input ready);
    modport sink (input valid, input tag_number, input is_context, input field_kind,
                  input length_value, input bool_value, input header_bytes,
                  input status, output ready);
endinterface

>>> rtl/bacnet_tag_header_decoder.sv
// top level of the tag header decoder: parser state and result register
// depends on bthd_pkg, bthd_stream_if and bthd_parse
// result: a header's result is registered and is valid in the cycle after its last octet is taken
// throughput: one octet per cycle; the single result register holds input only
// while a result waits and the sink is not ready
// reset: asynchronous, active low; parser returns to idle, result register empty
module bacnet_tag_header_decoder
    import bthd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    bthd_byte_if.sink    byte_stream,
    bthd_hdr_if.source   header_out
);

    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      res_reg;
    result_t      res_next;
    logic         res_valid_reg;
    logic         res_valid_next;
    logic         emit;
    logic         accept;

    bthd_parse u_parse (
        .state        (state_reg),
        .byte_in      (byte_stream.byte_in),
        .header_start (byte_stream.header_start),
        .state_next   (state_next),
        .emit         (emit),
        .result       (res_next)
    );

    assign byte_stream.ready = !res_valid_reg || header_out.ready;
    assign accept            = byte_stream.valid && byte_stream.ready;

    always_comb
    begin
        if (accept)
            res_valid_next = emit;
        else if (header_out.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '{PH_IDLE, 8'd0, 1'b0, 3'd0, 32'd0, 3'd0, 3'd0};
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                state_reg <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
            res_reg <= res_next;
    end

    assign header_out.valid        = res_valid_reg;
    assign header_out.tag_number   = res_reg.tag_number;
    assign header_out.is_context   = res_reg.is_context;
    assign header_out.field_kind   = res_reg.field_kind;
    assign header_out.length_value = res_reg.length_value;
    assign header_out.bool_value   = res_reg.bool_value;
    assign header_out.header_bytes = res_reg.header_bytes;
    assign header_out.status       = res_reg.status;

endmodule

>>> rtl/bthd_parse.sv
// next-state and result logic of the tag header parser for one octet
// depends on bthd_pkg
module bthd_parse
    import bthd_pkg::*;
(
    input  parse_state_t state,
    input  logic [7:0]   byte_in,
    input  logic         header_start,
    output parse_state_t state_next,
    output logic         emit,
    output result_t      result
);

    always_comb
    begin
        parse_state_t s;
        logic         resolve;
        s       = state;
        resolve = 1'b0;
        emit    = 1'b0;
        result  = '0;

        if (header_start)
        begin
            s.lvt             = byte_in[2:0];
            s.context_class   = byte_in[3];
            s.tag_number      = {4'd0, byte_in[7:4]};
            s.length_acc      = '0;
            s.bytes_remaining = '0;
            s.bytes_seen      = 3'd1;
            if (byte_in[7:4] == TAG_EXTENDED)
                s.phase = PH_EXT_TAG;
            else
                resolve = 1'b1;
        end
        else
        begin
            case (state.phase)
                PH_EXT_TAG:
                begin
                    s.bytes_seen = state.bytes_seen + 3'd1;
                    if (byte_in == TAG_RESERVED)
                    begin
                        emit          = 1'b1;
                        result.status = STAT_RSV_TAG;
                    end
                    else
                    begin
                        s.tag_number = byte_in;
                        resolve      = 1'b1;
                    end
                end
                PH_LEN_FIRST:
                begin
                    s.bytes_seen = state.bytes_seen + 3'd1;
                    if (byte_in == LEN_MARK_16 || byte_in == LEN_MARK_32)
                    begin
                        s.bytes_remaining = (byte_in == LEN_MARK_16) ? 3'd2 : 3'd4;
                        s.length_acc      = '0;
                        s.phase           = PH_LEN_MORE;
                    end
                    else
                    begin
                        emit                = 1'b1;
                        result.tag_number   = state.tag_number;
                        result.length_value = {24'd0, byte_in};
                    end
                end
                PH_LEN_MORE:
                begin
                    s.bytes_seen      = state.bytes_seen + 3'd1;
                    s.length_acc      = {state.length_acc[23:0], byte_in};
                    s.bytes_remaining = state.bytes_remaining - 3'd1;
                    if (s.bytes_remaining == 3'd0)
                    begin
                        emit                = 1'b1;
                        result.tag_number   = state.tag_number;
                        result.length_value = s.length_acc;
                    end
                end
                default:
                begin
                    s = state;
                end
            endcase
        end

        if (resolve)
        begin
            result.tag_number = s.tag_number;
            emit              = 1'b1;
            if (!s.context_class && s.tag_number == TAG_APP_BOOL)
            begin
                result.field_kind = KIND_BOOLEAN;
                if (s.lvt > 3'd1)
                    result.status = STAT_BAD_BOOL;
                else
                    result.bool_value = s.lvt[0];
            end
            else if (s.lvt == LVT_OPENING)
                result.field_kind = KIND_OPENING;
            else if (s.lvt == LVT_CLOSING)
                result.field_kind = KIND_CLOSING;
            else if (s.lvt < LVT_EXT_LEN)
                result.length_value = {29'd0, s.lvt};
            else
            begin
                emit    = 1'b0;
                s.phase = PH_LEN_FIRST;
            end
        end

        result.is_context   = s.context_class;
        result.header_bytes = s.bytes_seen;
        if (emit)
            s.phase = PH_IDLE;
        state_next = s;
    end

endmodule

>>> rtl/bthd_checker.sv
// port-level assertions for the tag header decoder, bound to the top level
// depends on bthd_pkg and bacnet_tag_header_decoder
module bthd_checker
    import bthd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  tag_number,
    input logic [1:0]  field_kind,
    input logic [31:0] length_value,
    input logic [2:0]  header_bytes,
    input logic [1:0]  status
);

    // a stalled transaction keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a new result appears in the cycle after an accepted octet
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted octet");

    // input is taken whenever the result register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

    // reserved tag results carry fixed fields
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_RSV_TAG |->
            tag_number == 8'd0 && field_kind == KIND_LENGTH &&
            length_value == 32'd0 && header_bytes == 3'd2)
        else $error("bad reserved tag result");

    // only length headers carry a length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && field_kind != KIND_LENGTH |-> length_value == 32'd0)
        else $error("length on a non-length header");

endmodule

bind bacnet_tag_header_decoder bthd_checker u_bthd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (byte_stream.valid),
    .in_ready     (byte_stream.ready),
    .out_valid    (header_out.valid),
    .out_ready    (header_out.ready),
    .tag_number   (header_out.tag_number),
    .field_kind   (header_out.field_kind),
    .length_value (header_out.length_value),
    .header_bytes (header_out.header_bytes),
    .status       (header_out.status)
);

>>> test/tb_top.sv
// testbench for bacnet_tag_header_decoder: octet stream in, decoded tag headers out
// predicts each header from the accepted octets and compares every result field
// depends on bthd_pkg, bthd_stream_if and the decoder rtl
`timescale 1ns / 1ps

module tb_top;
    import bthd_pkg::*;

    class header_decode_tracker;
        parse_state_t st;
        result_t      pending_headers[$];
        int unsigned  mismatch_count;

        function new();
            st = '0;
            st.phase = PH_IDLE;
            mismatch_count = 0;
        endfunction

        function void finish_header(logic [7:0] tag, logic [1:0] kind, logic [31:0] len,
                                    logic bval, logic [1:0] stat);
            result_t r;
            r.tag_number   = tag;
            r.is_context   = st.context_class;
            r.field_kind   = kind;
            r.length_value = len;
            r.bool_value   = bval;
            r.header_bytes = st.bytes_seen;
            r.status       = stat;
            pending_headers.push_back(r);
            st.phase = PH_IDLE;
        endfunction

        // tag number known, decide what the lvt field means
        function void resolve_lvt();
            if (!st.context_class && st.tag_number == TAG_APP_BOOL)
            begin
                if (st.lvt > 3'd1)
                    finish_header(st.tag_number, KIND_BOOLEAN, 32'd0, 1'b0, STAT_BAD_BOOL);
                else
                    finish_header(st.tag_number, KIND_BOOLEAN, 32'd0, st.lvt[0], STAT_OK);
            end
            else if (st.lvt == LVT_OPENING)
                finish_header(st.tag_number, KIND_OPENING, 32'd0, 1'b0, STAT_OK);
            else if (st.lvt == LVT_CLOSING)
                finish_header(st.tag_number, KIND_CLOSING, 32'd0, 1'b0, STAT_OK);
            else if (st.lvt < LVT_EXT_LEN)
                finish_header(st.tag_number, KIND_LENGTH, {29'd0, st.lvt}, 1'b0, STAT_OK);
            else
                st.phase = PH_LEN_FIRST;
        endfunction

        function void take_octet(logic [7:0] octet, logic first);
            if (first)
            begin
                st.lvt             = octet[2:0];
                st.context_class   = octet[3];
                st.tag_number      = {4'd0, octet[7:4]};
                st.length_acc      = 32'd0;
                st.bytes_remaining = 3'd0;
                st.bytes_seen      = 3'd1;
                if (octet[7:4] == TAG_EXTENDED)
                    st.phase = PH_EXT_TAG;
                else
                    resolve_lvt();
                return;
            end
            case (st.phase)
                PH_EXT_TAG:
                begin
                    st.bytes_seen = st.bytes_seen + 3'd1;
                    if (octet == TAG_RESERVED)
                        finish_header(8'd0, KIND_LENGTH, 32'd0, 1'b0, STAT_RSV_TAG);
                    else
                    begin
                        st.tag_number = octet;
                        resolve_lvt();
                    end
                end
                PH_LEN_FIRST:
                begin
                    st.bytes_seen = st.bytes_seen + 3'd1;
                    if (octet == LEN_MARK_16 || octet == LEN_MARK_32)
                    begin
                        st.bytes_remaining = (octet == LEN_MARK_16) ? 3'd2 : 3'd4;
                        st.length_acc      = 32'd0;
                        st.phase           = PH_LEN_MORE;
                    end
                    else
                        finish_header(st.tag_number, KIND_LENGTH, {24'd0, octet}, 1'b0, STAT_OK);
                end
                PH_LEN_MORE:
                begin
                    st.bytes_seen      = st.bytes_seen + 3'd1;
                    st.length_acc      = {st.length_acc[23:0], octet};
                    st.bytes_remaining = st.bytes_remaining - 3'd1;
                    if (st.bytes_remaining == 3'd0)
                        finish_header(st.tag_number, KIND_LENGTH, st.length_acc, 1'b0, STAT_OK);
                end
                default:
                begin
                end
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0h, actual %0h", name, want, got);
                mismatch_count++;
            end
        endfunction

        function void match_header(result_t got);
            result_t want;
            if (pending_headers.size() == 0)
            begin
                $error("unexpected header transaction: tag_number %0h", got.tag_number);
                mismatch_count++;
                return;
            end
            want = pending_headers.pop_front();
            compare_field("tag_number", 32'(want.tag_number), 32'(got.tag_number));
            compare_field("is_context", 32'(want.is_context), 32'(got.is_context));
            compare_field("field_kind", 32'(want.field_kind), 32'(got.field_kind));
            compare_field("length_value", want.length_value, got.length_value);
            compare_field("bool_value", 32'(want.bool_value), 32'(got.bool_value));
            compare_field("header_bytes", 32'(want.header_bytes), 32'(got.header_bytes));
            compare_field("status", 32'(want.status), 32'(got.status));
        endfunction
    endclass

    localparam int QUIET_LIMIT = 1000;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int PHASE_OCTETS = 125;

    logic clk;
    logic rst_n;

    bthd_byte_if byte_ch ();
    bthd_hdr_if  hdr_ch ();

    bacnet_tag_header_decoder DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_stream (byte_ch),
        .header_out  (hdr_ch)
    );

    header_decode_tracker tracker = new();

    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;
    logic        hold_off_pending;
    int unsigned counted_octets;
    int unsigned quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // sink side: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_off_done;
        hold_off_done = 1'b0;
        hdr_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_pending && !hold_off_done)
            begin
                hold_off_done = 1'b1;
                hdr_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(posedge clk);
            end
            else
                hdr_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hdr_ch.valid && hdr_ch.ready)
            tracker.match_header({hdr_ch.tag_number, hdr_ch.is_context, hdr_ch.field_kind,
                                  hdr_ch.length_value, hdr_ch.bool_value,
                                  hdr_ch.header_bytes, hdr_ch.status});
    end

    always @(posedge clk)
    begin
        if ((byte_ch.valid && byte_ch.ready) || (hdr_ch.valid && hdr_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic logic [7:0] rand_octet();
        case ($urandom_range(7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic send_octet(input logic [7:0] octet, input logic first);
        while ($urandom_range(99) < src_idle_pct)
        begin
            byte_ch.valid <= 1'b0;
            @(posedge clk);
        end
        byte_ch.valid        <= 1'b1;
        byte_ch.byte_in      <= octet;
        byte_ch.header_start <= first;
        @(posedge clk);
        while (!byte_ch.ready) @(posedge clk);
        tracker.take_octet(octet, first);
    endtask

    task automatic send_header(input bit cut_short);
        logic [7:0] octets[$];
        logic [3:0] nibble;
        logic       ctx;
        logic [2:0] lvt;
        logic [7:0] tag;
        bit         reserved;
        int         keep;
        nibble = ($urandom_range(4) == 0) ? TAG_EXTENDED : 4'($urandom_range(14));
        if ($urandom_range(5) == 0)
            nibble = 4'd1;
        ctx = 1'($urandom_range(1));
        lvt = ($urandom_range(2) == 0) ? LVT_EXT_LEN : 3'($urandom_range(7));
        octets.push_back({nibble, ctx, lvt});
        tag = {4'd0, nibble};
        reserved = 1'b0;
        if (nibble == TAG_EXTENDED)
        begin
            tag = ($urandom_range(15) == 0) ? TAG_RESERVED : 8'($urandom_range(254));
            reserved = (tag == TAG_RESERVED);
            octets.push_back(tag);
        end
        if (!reserved && lvt == LVT_EXT_LEN && !(ctx == 1'b0 && tag == TAG_APP_BOOL))
        begin
            case ($urandom_range(2))
                0: octets.push_back(8'($urandom_range(253)));
                1:
                begin
                    octets.push_back(LEN_MARK_16);
                    repeat (2) octets.push_back(rand_octet());
                end
                default:
                begin
                    octets.push_back(LEN_MARK_32);
                    repeat (4) octets.push_back(rand_octet());
                end
            endcase
        end
        keep = octets.size();
        if (cut_short && keep > 1)
            keep = $urandom_range(keep - 1, 1);
        for (int i = 0; i < keep; i++)
            send_octet(octets[i], i == 0);
        counted_octets += keep;
    endtask

    task automatic run_headers(input int unsigned target);
        while (counted_octets < target)
        begin
            send_header($urandom_range(9) == 0);
            if ($urandom_range(9) == 0)
                repeat ($urandom_range(3, 1)) send_octet(rand_octet(), 1'b0);
        end
    endtask

    initial
    begin
        logic [8:0]  directed_octets[26];
        int unsigned src_pcts[4];
        int unsigned sink_pcts[4];
        directed_octets = '{
            9'h110, 9'h111, 9'h117, 9'h13E, 9'h13F,           // boolean false, boolean true, bad boolean, open, close
            9'h0AB,                                           // ignored while idle
            9'h1F9, 9'h00E,                                   // extended tag 14
            9'h1FC, 9'h0FF,                                   // reserved extended tag
            9'h145, 9'h0FD,                                   // length octet 253
            9'h14D, 9'h0FE, 9'h012, 9'h034,                   // 16-bit length
            9'h1F5, 9'h000, 9'h0FF, 9'h0DE, 9'h0AD, 9'h0BE, 9'h0EF, // 32-bit length
            9'h125, 9'h0FF, 9'h124                            // restart mid header
        };
        src_pcts  = '{0, 56, 0, 32};
        sink_pcts = '{0, 0, 56, 32};

        rst_n                <= 1'b0;
        byte_ch.valid        <= 1'b0;
        byte_ch.byte_in      <= 8'd0;
        byte_ch.header_start <= 1'b0;
        hold_off_pending     <= 1'b0;
        src_idle_pct          = 0;
        sink_stall_pct       <= 0;
        counted_octets        = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_octets[i])
            send_octet(directed_octets[i][7:0], directed_octets[i][8]);

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct    = src_pcts[p];
            sink_stall_pct <= sink_pcts[p];
            run_headers(counted_octets + PHASE_OCTETS);
        end

        // long sink hold-off while octets keep coming
        src_idle_pct      = 0;
        sink_stall_pct   <= 0;
        hold_off_pending <= 1'b1;
        run_headers(counted_octets + 50);

        byte_ch.valid <= 1'b0;
        while (tracker.pending_headers.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (tracker.mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
